FILE: sv/log_bucket_quantile_sketch_macros.svh
// assertion macros for the sketch rtl
// expects clk and rst_n in the scope of each use
`ifndef LOG_BUCKET_QUANTILE_SKETCH_MACROS_SVH
`define LOG_BUCKET_QUANTILE_SKETCH_MACROS_SVH

// condition holds at every edge out of reset
`define LBQS_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define LBQS_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: sv/lbqs_pkg.sv
// shared types, constants and helper functions of the log-bucket sketch
// no dependencies
package lbqs_pkg;

  localparam int SLOTS      = 64;
  localparam int SLOT_W     = 6;
  localparam int USED_W     = 7;
  localparam int KEY_W      = 16;
  localparam int TALLY_W    = 32;
  localparam int INV_W      = 24;
  localparam int QP_W       = 8;
  localparam int PCT_W      = 7;
  localparam int RUN_W      = 39;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  localparam logic [PCT_W-1:0]  Q_DEFAULT = 7'd50;
  localparam logic [QP_W-1:0]   Q_MOD     = 8'd101;
  localparam logic [QP_W-1:0]   Q_MOD2    = 8'd202;
  localparam logic [USED_W-1:0] SLOT_CAP  = 7'd64;

  localparam logic CFG_MAX_BUCKETS = 1'b0;
  localparam logic CFG_INV_LOG2    = 1'b1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_QUERY  = 2'd2,
    OP_DUMP   = 2'd3
  } op_t;

  // request handed from front to back
  typedef struct packed {
    op_t             op;
    logic [KEY_W-1:0] key;
    logic [QP_W-1:0]  qp;
  } req_t;

  // one result item
  typedef struct packed {
    op_t                kind;
    logic [KEY_W-1:0]   index;
    logic [TALLY_W-1:0] count;
    logic [TALLY_W-1:0] total;
    logic [USED_W-1:0]  used;
    logic               empty;
    logic               last;
  } result_t;

  // saturating increment of a count
  function automatic logic [TALLY_W-1:0] sat_inc(input logic [TALLY_W-1:0] c);
    return (c == {TALLY_W{1'b1}}) ? c : c + 1'b1;
  endfunction

  // percent modulo 101, zero meaning fifty
  function automatic logic [PCT_W-1:0] pct_of(input logic [QP_W-1:0] qp);
    logic [QP_W-1:0] r;
    if (qp == '0) r = QP_W'(Q_DEFAULT);
    else if (qp >= Q_MOD2) r = qp - Q_MOD2;
    else if (qp >= Q_MOD) r = qp - Q_MOD;
    else r = qp;
    return r[PCT_W-1:0];
  endfunction

endpackage

FILE: sv/lbqs_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module lbqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata <= mem_r[raddr];
  end

endmodule

FILE: sv/lbqs_fifo.sv
// short request queue between front and back
// depends on lbqs_pkg
module lbqs_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  lbqs_pkg::req_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output lbqs_pkg::req_t pop_data
);

  lbqs_pkg::req_t                  mem_r [lbqs_pkg::FIFO_DEPTH];
  logic [lbqs_pkg::FIFO_AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [lbqs_pkg::FIFO_AW:0]      count_r;
  logic                            do_push, do_pop;

  assign push_ready = (count_r != (lbqs_pkg::FIFO_AW+1)'(lbqs_pkg::FIFO_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        mem_r[wr_ptr_r] <= push_data;
        wr_ptr_r        <= wr_ptr_r + 1'b1;
      end
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

endmodule

FILE: sv/lbqs_front.sv
// front end: takes requests and turns insert values into bucket keys
// depends on lbqs_pkg
module lbqs_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_operation,
  input  logic [47:0]                   in_sample_value,
  input  logic [lbqs_pkg::QP_W-1:0]     in_quantile_percent,
  input  logic [lbqs_pkg::INV_W-1:0]    inv_log2_base,
  output logic                          q_valid,
  input  logic                          q_ready,
  output lbqs_pkg::req_t                q_req
);

  typedef enum logic [2:0] {F_IDLE, F_NORM, F_SQ, F_MUL, F_PUSH} fstate_t;

  fstate_t                          state_r;
  lbqs_pkg::op_t                    op_r;
  logic [lbqs_pkg::QP_W-1:0]        qp_r;
  logic [47:0]                      w_r;
  logic [5:0]                       p_r;
  logic [31:0]                      x_r;
  logic [15:0]                      frac_r;
  logic [3:0]                       step_r;
  logic [lbqs_pkg::KEY_W-1:0]       key_r;
  logic [63:0]                      sq;
  logic [32:0]                      sq_top;
  logic [45:0]                      prod;

  assign in_ready = (state_r == F_IDLE);
  assign q_valid  = (state_r == F_PUSH);
  assign q_req    = '{op: op_r, key: key_r, qp: qp_r};

  // one squaring step of the mantissa, Q1.31 kept
  assign sq     = 64'(x_r) * 64'(x_r);
  assign sq_top = sq[63:31];
  // log2 in Q6.16 times reciprocal in Q4.20
  assign prod   = 46'({p_r, frac_r}) * 46'(inv_log2_base);

  // front sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            op_r  <= lbqs_pkg::op_t'(in_operation);
            qp_r  <= in_quantile_percent;
            w_r   <= (in_sample_value == '0) ? 48'd1 : in_sample_value;
            p_r   <= 6'd47;
            key_r <= '0;
            state_r <= (lbqs_pkg::op_t'(in_operation) == lbqs_pkg::OP_INSERT) ?
                       F_NORM : F_PUSH;
          end
        end
        F_NORM: begin
          // leading-one search, a byte or a bit per cycle
          if (w_r[47:40] == '0) begin
            w_r <= {w_r[39:0], 8'd0};
            p_r <= p_r - 6'd8;
          end else if (!w_r[47]) begin
            w_r <= {w_r[46:0], 1'b0};
            p_r <= p_r - 6'd1;
          end else begin
            x_r     <= w_r[47:16];
            frac_r  <= '0;
            step_r  <= '0;
            state_r <= F_SQ;
          end
        end
        F_SQ: begin
          frac_r <= {frac_r[14:0], sq_top[32]};
          x_r    <= sq_top[32] ? sq_top[32:1] : sq_top[31:0];
          step_r <= step_r + 1'b1;
          if (step_r == 4'd15) state_r <= F_MUL;
        end
        F_MUL: begin
          key_r   <= lbqs_pkg::KEY_W'(prod[45:36]);
          state_r <= F_PUSH;
        end
        F_PUSH: begin
          if (q_ready) state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/lbqs_back.sv
// back end: bucket table, insert scan, ordered walks and result register
// depends on lbqs_pkg and lbqs_ram
module lbqs_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  lbqs_pkg::req_t                q_req,
  input  logic [lbqs_pkg::USED_W-1:0]   max_buckets,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lbqs_pkg::result_t             out_res
);

  localparam int KW = lbqs_pkg::KEY_W;
  localparam int TW = lbqs_pkg::TALLY_W;
  localparam int UW = lbqs_pkg::USED_W;
  localparam int SW = lbqs_pkg::SLOT_W;
  localparam int RW = lbqs_pkg::RUN_W;

  typedef enum logic [2:0] {B_IDLE, B_SCAN, B_UPDATE, B_PASS, B_VISIT, B_EMIT} bstate_t;

  bstate_t             state_r;
  lbqs_pkg::req_t      req_r;
  logic [UW-1:0]       used_r;
  logic [TW-1:0]       total_r;
  logic [UW-1:0]       issue_r;
  logic                pend_r;
  logic [SW-1:0]       pend_slot_r;
  logic                match_r, have_min_r;
  logic [SW-1:0]       match_slot_r, min_slot_r;
  logic [TW-1:0]       match_tally_r, min_tally_r;
  logic [KW-1:0]       min_key_r;
  logic                first_r, best_found_r;
  logic [KW-1:0]       prev_key_r, best_key_r;
  logic [TW-1:0]       best_tally_r;
  logic [UW-1:0]       pass_r;
  logic [RW-1:0]       run_r, tq_r;
  lbqs_pkg::result_t   res_r, out_r;
  logic                out_valid_r;

  logic                ram_we;
  logic [SW-1:0]       ram_waddr;
  logic [KW+TW-1:0]    ram_wdata, ram_rdata;
  logic [KW-1:0]       rd_key;
  logic [TW-1:0]       rd_tally;
  logic                scan_done;
  logic [UW-1:0]       lim;
  logic [KW-1:0]       upd_key;
  logic [TW-1:0]       upd_tally;
  logic [UW-1:0]       upd_used;
  logic [RW-1:0]       run_n;
  logic [RW+6:0]       run100;
  logic                pass_last;

  lbqs_ram #(.WIDTH(KW + TW), .DEPTH(lbqs_pkg::SLOTS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (issue_r[SW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_key    = ram_rdata[KW+TW-1:TW];
  assign rd_tally  = ram_rdata[TW-1:0];
  assign q_ready   = (state_r == B_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_r;
  assign scan_done = (issue_r == used_r) && !pend_r;

  // effective table limit
  always_comb begin
    if (max_buckets == '0) lim = UW'(1);
    else if (max_buckets > lbqs_pkg::SLOT_CAP) lim = lbqs_pkg::SLOT_CAP;
    else lim = max_buckets;
  end

  // table update for an insert: bump a match, replace a victim or append
  always_comb begin
    upd_key  = req_r.key;
    upd_used = used_r;
    if (match_r) begin
      ram_waddr = match_slot_r;
      upd_tally = lbqs_pkg::sat_inc(match_tally_r);
    end else if (used_r >= lim) begin
      ram_waddr = min_slot_r;
      upd_tally = lbqs_pkg::sat_inc(min_tally_r);
    end else begin
      ram_waddr = used_r[SW-1:0];
      upd_tally = TW'(1);
      upd_used  = used_r + 1'b1;
    end
    ram_wdata = {upd_key, upd_tally};
    ram_we    = (state_r == B_UPDATE);
  end

  // quantile walk: stop once 100 * running count exceeds total * q, or at the last bucket
  assign run_n     = run_r + RW'(best_tally_r);
  assign run100    = ((RW+7)'(run_n) << 6) + ((RW+7)'(run_n) << 5) + ((RW+7)'(run_n) << 2);
  assign pass_last = ((pass_r + 1'b1) == used_r);

  // back sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      used_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      // result taken and nothing new loaded behind it
      if (out_valid_r && out_ready && state_r != B_EMIT) out_valid_r <= 1'b0;

      // shared table sweep, one entry a cycle
      if (state_r == B_SCAN || state_r == B_PASS) begin
        if (issue_r != used_r) begin
          issue_r     <= issue_r + 1'b1;
          pend_r      <= 1'b1;
          pend_slot_r <= issue_r[SW-1:0];
        end else begin
          pend_r <= 1'b0;
        end
      end

      unique case (state_r)
        B_IDLE: begin
          if (q_valid) begin
            req_r <= q_req;
            unique case (q_req.op)
              lbqs_pkg::OP_INSERT: begin
                issue_r    <= '0;
                pend_r     <= 1'b0;
                match_r    <= 1'b0;
                have_min_r <= 1'b0;
                state_r    <= B_SCAN;
              end
              lbqs_pkg::OP_CLEAR: begin
                used_r  <= '0;
                total_r <= '0;
                res_r   <= '{kind: lbqs_pkg::OP_CLEAR, index: '0, count: '0, total: '0,
                             used: '0, empty: 1'b1, last: 1'b1};
                state_r <= B_EMIT;
              end
              default: begin
                if (used_r == '0) begin
                  res_r   <= '{kind: q_req.op, index: '0, count: '0, total: total_r,
                               used: '0, empty: 1'b1, last: 1'b1};
                  state_r <= B_EMIT;
                end else begin
                  tq_r         <= RW'(total_r) * RW'(lbqs_pkg::pct_of(q_req.qp));
                  run_r        <= '0;
                  pass_r       <= '0;
                  first_r      <= 1'b1;
                  issue_r      <= '0;
                  pend_r       <= 1'b0;
                  best_found_r <= 1'b0;
                  state_r      <= B_PASS;
                end
              end
            endcase
          end
        end
        B_SCAN: begin
          if (pend_r) begin
            if (!match_r && rd_key == req_r.key) begin
              match_r       <= 1'b1;
              match_slot_r  <= pend_slot_r;
              match_tally_r <= rd_tally;
            end
            if (!have_min_r || rd_tally < min_tally_r ||
                (rd_tally == min_tally_r && rd_key < min_key_r)) begin
              have_min_r  <= 1'b1;
              min_slot_r  <= pend_slot_r;
              min_tally_r <= rd_tally;
              min_key_r   <= rd_key;
            end
          end
          if (scan_done) state_r <= B_UPDATE;
        end
        B_UPDATE: begin
          used_r  <= upd_used;
          total_r <= lbqs_pkg::sat_inc(total_r);
          res_r   <= '{kind: lbqs_pkg::OP_INSERT, index: upd_key, count: upd_tally,
                       total: lbqs_pkg::sat_inc(total_r), used: upd_used,
                       empty: (upd_used == '0), last: 1'b1};
          state_r <= B_EMIT;
        end
        B_PASS: begin
          // smallest key above the one last visited
          if (pend_r && (first_r || rd_key > prev_key_r) &&
              (!best_found_r || rd_key < best_key_r)) begin
            best_found_r <= 1'b1;
            best_key_r   <= rd_key;
            best_tally_r <= rd_tally;
          end
          if (scan_done) state_r <= B_VISIT;
        end
        B_VISIT: begin
          pass_r     <= pass_r + 1'b1;
          prev_key_r <= best_key_r;
          first_r    <= 1'b0;
          run_r      <= run_n;
          if (req_r.op == lbqs_pkg::OP_DUMP) begin
            res_r   <= '{kind: lbqs_pkg::OP_DUMP, index: best_key_r, count: best_tally_r,
                         total: total_r, used: used_r, empty: 1'b0, last: pass_last};
            state_r <= B_EMIT;
          end else if (run100 > (RW+7)'(tq_r) || pass_last) begin
            res_r   <= '{kind: lbqs_pkg::OP_QUERY, index: best_key_r, count: best_tally_r,
                         total: total_r, used: used_r, empty: 1'b0, last: 1'b1};
            state_r <= B_EMIT;
          end else begin
            issue_r      <= '0;
            pend_r       <= 1'b0;
            best_found_r <= 1'b0;
            state_r      <= B_PASS;
          end
        end
        B_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_r       <= res_r;
            out_valid_r <= 1'b1;
            if (res_r.last) begin
              state_r <= B_IDLE;
            end else begin
              issue_r      <= '0;
              pend_r       <= 1'b0;
              best_found_r <= 1'b0;
              state_r      <= B_PASS;
            end
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/log_bucket_quantile_sketch.sv
// top level of the log-bucket quantile sketch: config registers and wiring
// depends on lbqs_pkg, lbqs_front, lbqs_fifo, lbqs_back and the macros header
//
//   port group | direction | handshake          | carries
//   in_*       | input     | in_valid/in_ready   | operation, sample value, percent
//   out_*      | output    | out_valid/out_ready | one result item
//   cfg_*      | input     | cfg_we              | register index and data
//
// an insert passes through the front (byte/bit leading-one search,
// 16 squaring steps on one 32x32 multiplier, one key multiply), then through
// the back, which sweeps the n stored buckets through the table ram read port.
// a query or dump makes one sweep per visited bucket.
// reset is synchronous, no clearing pass; a four-deep request queue lets the
// front accept while the back or the result register is stalled.
`include "log_bucket_quantile_sketch_macros.svh"

module log_bucket_quantile_sketch (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_operation,
  input  logic [47:0]                        in_sample_value,
  input  logic [lbqs_pkg::QP_W-1:0]          in_quantile_percent,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         out_result_kind,
  output logic [lbqs_pkg::KEY_W-1:0]         out_bucket_index,
  output logic [lbqs_pkg::TALLY_W-1:0]       out_bucket_count,
  output logic [lbqs_pkg::TALLY_W-1:0]       out_total_count,
  output logic [lbqs_pkg::USED_W-1:0]        out_buckets_used,
  output logic                               out_table_empty,
  output logic                               out_last,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [lbqs_pkg::INV_W-1:0]         cfg_wdata
);

  logic [lbqs_pkg::USED_W-1:0] max_buckets_r;
  logic [lbqs_pkg::INV_W-1:0]  inv_log2_base_r;
  logic                        fq_valid, fq_ready, bq_valid, bq_ready;
  lbqs_pkg::req_t              fq_req, bq_req;
  lbqs_pkg::result_t           res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_buckets_r   <= lbqs_pkg::SLOT_CAP;
      inv_log2_base_r <= 24'd661579;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lbqs_pkg::CFG_MAX_BUCKETS: max_buckets_r   <= cfg_wdata[lbqs_pkg::USED_W-1:0];
        lbqs_pkg::CFG_INV_LOG2:    inv_log2_base_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lbqs_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (in_operation),
    .in_sample_value     (in_sample_value),
    .in_quantile_percent (in_quantile_percent),
    .inv_log2_base       (inv_log2_base_r),
    .q_valid             (fq_valid),
    .q_ready             (fq_ready),
    .q_req               (fq_req)
  );

  lbqs_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_req),
    .pop_valid  (bq_valid),
    .pop_ready  (bq_ready),
    .pop_data   (bq_req)
  );

  lbqs_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (bq_valid),
    .q_ready     (bq_ready),
    .q_req       (bq_req),
    .max_buckets (max_buckets_r),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_res     (res)
  );

  assign out_result_kind  = res.kind;
  assign out_bucket_index = res.index;
  assign out_bucket_count = res.count;
  assign out_total_count  = res.total;
  assign out_buckets_used = res.used;
  assign out_table_empty  = res.empty;
  assign out_last         = res.last;

  // checks
  `LBQS_IMPLY(a_empty_zero, out_valid && out_table_empty, out_bucket_index == '0 && out_bucket_count == '0, "empty result carries a bucket")
  `LBQS_IMPLY(a_clear_empty, out_valid && out_result_kind == lbqs_pkg::OP_CLEAR, out_table_empty && out_total_count == '0, "clear result not empty")
  `LBQS_IMPLY(a_used_cap, out_valid, out_buckets_used <= lbqs_pkg::SLOT_CAP, "bucket count above capacity")
  `LBQS_IMPLY(a_insert_nonempty, out_valid && out_result_kind == lbqs_pkg::OP_INSERT, !out_table_empty && out_bucket_count != '0, "insert left empty bucket")

endmodule
